// ===== rtl/hssc_pkg.sv =====
package hssc_pkg;

    localparam int SECTOR_COUNT       = 6;
    localparam int QUEUE_DEPTH_DEF    = 2;
    localparam logic [14:0] DUTY_MAX  = 15'h7fff;

    typedef enum logic [1:0] {
        MODE_OPEN = 2'd0,
        MODE_POS  = 2'd1,
        MODE_NEG  = 2'd2
    } phase_mode_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [2:0]        sector;
        logic signed [3:0] direction;
        logic              drive_neg;
        logic [14:0]       mag;
    } cmd_t;

    typedef struct packed {
        phase_mode_t w;
        phase_mode_t v;
        phase_mode_t u;
    } phase_modes_t;

    // hall code 5,1,3,2,6,4 maps to sectors 1..6, others are invalid
    function automatic logic [2:0] sector_of_code(input logic [2:0] code);
        logic [2:0] sec;
        case (code)
            3'd1:    sec = 3'd2;
            3'd2:    sec = 3'd4;
            3'd3:    sec = 3'd3;
            3'd4:    sec = 3'd6;
            3'd5:    sec = 3'd1;
            3'd6:    sec = 3'd5;
            default: sec = 3'd0;
        endcase
        return sec;
    endfunction

    // sector centre in 30 degree units
    function automatic logic signed [3:0] centre_of_sector(input logic [2:0] sec);
        logic signed [3:0] c;
        case (sec)
            3'd1:    c = -4'sd4;
            3'd2:    c = -4'sd2;
            3'd4:    c = 4'sd2;
            3'd5:    c = 4'sd4;
            3'd6:    c = 4'sd6;
            default: c = 4'sd0;
        endcase
        return c;
    endfunction

    function automatic phase_modes_t modes_of_sector(input logic [2:0] sec);
        phase_modes_t m;
        case (sec)
            3'd1:    m = '{w: MODE_OPEN, v: MODE_NEG,  u: MODE_POS};
            3'd2:    m = '{w: MODE_NEG,  v: MODE_OPEN, u: MODE_POS};
            3'd3:    m = '{w: MODE_NEG,  v: MODE_POS,  u: MODE_OPEN};
            3'd4:    m = '{w: MODE_OPEN, v: MODE_POS,  u: MODE_NEG};
            3'd5:    m = '{w: MODE_POS,  v: MODE_OPEN, u: MODE_NEG};
            3'd6:    m = '{w: MODE_POS,  v: MODE_NEG,  u: MODE_OPEN};
            default: m = '{w: MODE_OPEN, v: MODE_OPEN, u: MODE_OPEN};
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/hssc_front.sv =====
module hssc_front
    import hssc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [2:0]         hall_bits,
    input  logic signed [15:0] duty_ref,
    input  logic               queue_full,
    output logic               in_ready,
    output logic               push,
    output cmd_t               cmd
);

    logic [2:0]        prev_sector_reg, prev_sector_next;
    logic signed [3:0] kept_dir_reg, kept_dir_next;
    logic [2:0]        sec;
    logic signed [4:0] diff_raw;
    logic signed [4:0] diff_wrap;
    logic [15:0]       neg_ref;
    logic [14:0]       mag;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb begin
        sec      = sector_of_code(hall_bits);
        diff_raw = $signed({2'b00, sec}) - $signed({2'b00, prev_sector_reg});
        if (diff_raw > 5'sd1) begin
            diff_wrap = diff_raw - 5'sd6;
        end else if (diff_raw < -5'sd1) begin
            diff_wrap = diff_raw + 5'sd6;
        end else begin
            diff_wrap = diff_raw;
        end

        prev_sector_next = prev_sector_reg;
        kept_dir_next    = kept_dir_reg;
        if (push) begin
            prev_sector_next = sec;
            if (diff_wrap != 5'sd0) begin
                kept_dir_next = diff_wrap[3:0];
            end
        end

        // magnitude, most negative code saturates
        neg_ref = ~duty_ref + 16'd1;
        if (duty_ref > 16'sd0) begin
            mag = duty_ref[14:0];
        end else if (neg_ref[15]) begin
            mag = DUTY_MAX;
        end else begin
            mag = neg_ref[14:0];
        end

        cmd.sector    = sec;
        cmd.direction = kept_dir_next;
        cmd.drive_neg = !(duty_ref > 16'sd0);
        cmd.mag       = mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sector_reg <= 3'd0;
            kept_dir_reg    <= 4'sd0;
        end else begin
            prev_sector_reg <= prev_sector_next;
            kept_dir_reg    <= kept_dir_next;
        end
    end

endmodule

// ===== rtl/hssc_queue.sv =====
module hssc_queue
    import hssc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/hssc_back.sv =====
module hssc_back
    import hssc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_data
);

    logic              valid_reg, valid_next;
    logic [63:0]       data_reg, data_next;
    logic signed [4:0] angle_raw;
    logic signed [4:0] angle_wrap;
    phase_modes_t      modes;
    phase_mode_t       drive;
    logic [14:0]       duty_u, duty_v, duty_w;

    assign pop       = cmd_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        angle_raw = 5'(centre_of_sector(cmd.sector)) - 5'(cmd.direction);
        if (angle_raw > 5'sd6) begin
            angle_wrap = angle_raw - 5'sd12;
        end else if (angle_raw < -5'sd6) begin
            angle_wrap = angle_raw + 5'sd12;
        end else begin
            angle_wrap = angle_raw;
        end

        modes  = modes_of_sector(cmd.sector);
        drive  = cmd.drive_neg ? MODE_NEG : MODE_POS;
        duty_u = (modes.u == drive) ? cmd.mag : 15'd0;
        duty_v = (modes.v == drive) ? cmd.mag : 15'd0;
        duty_w = (modes.w == drive) ? cmd.mag : 15'd0;

        valid_next = valid_reg;
        data_next  = data_reg;
        if (pop) begin
            valid_next = 1'b1;
            data_next  = {2'b00, duty_w, duty_v, duty_u,
                          modes.w, modes.v, modes.u,
                          angle_wrap[3:0], cmd.direction, cmd.sector};
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

// ===== rtl/hall_six_step_commutator.sv =====
// an accepted transfer passes through the command queue, then the output register
// throughput: one item per cycle while the result side is ready, set by the output
//   register and the two-entry command queue between hall decode and drive generation
// reset: aresetn low at a clock edge empties the queue and output register and
//   clears previous sector and kept direction to zero
module hall_six_step_commutator
    import hssc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // hall_bits[2:0], duty_ref[18:3], zero pad
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // sector[2:0], direction[6:3], hall_angle[10:7],
                                       // phase_u_mode[12:11], phase_v_mode[14:13],
                                       // phase_w_mode[16:15], duty_u[31:17],
                                       // duty_v[46:32], duty_w[61:47], zero pad
);

    logic push;
    logic pop;
    logic queue_full;
    logic queue_not_empty;
    cmd_t front_cmd;
    cmd_t head_cmd;

    // front: hall decode, direction tracking, duty magnitude and polarity
    hssc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .hall_bits  (s_axis_tdata[2:0]),
        .duty_ref   ($signed(s_axis_tdata[18:3])),
        .queue_full (queue_full),
        .in_ready   (s_axis_tready),
        .push       (push),
        .cmd        (front_cmd)
    );

    // short command queue so either side can stall on its own
    hssc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (front_cmd),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_cmd)
    );

    // back: angle, phase drive modes and per-phase duty into the output register
    hssc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (queue_not_empty),
        .cmd       (head_cmd),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== verif/tb_hall_six_step_commutator.sv =====
module tb_hall_six_step_commutator;
    import hssc_pkg::*;

    // generous ceiling on the total simulation cycles for all test phases
    localparam int CYCLE_LIMIT = 300000;

    // hall code for each sector 0..6, three bits per entry, sector 0 in the low bits
    localparam logic [20:0] CODE_BY_SECTOR = {3'd4, 3'd6, 3'd2, 3'd3, 3'd1, 3'd5, 3'd0};
    // sector for each hall code 0..7, three bits per entry, code 0 in the low bits
    localparam logic [23:0] SECTOR_BY_CODE =
        {3'd0, 3'd5, 3'd1, 3'd6, 3'd3, 3'd4, 3'd2, 3'd0};

    // one expected drive result
    typedef struct packed {
        logic [2:0]        sector;
        logic signed [3:0] direction;
        logic signed [3:0] angle;
        phase_mode_t       u;
        phase_mode_t       v;
        phase_mode_t       w;
        logic [14:0]       duty_u;
        logic [14:0]       duty_v;
        logic [14:0]       duty_w;
    } drive_result_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // hall_bits[2:0], duty_ref[18:3], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // sector[2:0], direction[6:3], hall_angle[10:7],
                                       // phase_u_mode[12:11], phase_v_mode[14:13],
                                       // phase_w_mode[16:15], duty_u[31:17],
                                       // duty_v[46:32], duty_w[61:47], zero pad

    // predictor state, mirrors the commutator after each accepted transfer
    logic [2:0]        last_sector;
    logic signed [3:0] held_direction;

    drive_result_t pending_drives[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int mismatches     = 0;
    int transfers_in   = 0;
    int results_seen   = 0;

    hall_six_step_commutator u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // works out the drive result for one hall sample and advances the predictor state
    function automatic drive_result_t predict_drive(input logic [2:0] hall,
                                                    input logic signed [15:0] duty_req);
        drive_result_t r;
        phase_mode_t   modes[3];
        phase_mode_t   hot;
        int            diff;
        int            centre;
        int            ang;
        int            mag;
        logic [14:0]   duty_word;
        r.sector = SECTOR_BY_CODE[int'(hall) * 3 +: 3];
        // wrapped sector difference, moves to and from sector 0 count as well
        diff = int'(r.sector) - int'(last_sector);
        if (diff > 1) begin
            diff -= 6;
        end else if (diff < -1) begin
            diff += 6;
        end
        if (diff != 0) begin
            held_direction = 4'(diff);
        end
        last_sector = r.sector;
        r.direction = held_direction;
        // centres run -4,-2,0,2,4,6 for sectors 1..6, sector 0 sits at 0
        centre = (r.sector == 3'd0) ? 0 : 2 * int'(r.sector) - 6;
        ang = centre - int'(held_direction);
        if (ang > 6) begin
            ang -= 12;
        end else if (ang < -6) begin
            ang += 12;
        end
        r.angle = 4'(ang);
        // high side walks u,u,v,v,w,w over sectors 1..6, low side v,w,w,u,u,v
        modes[0] = MODE_OPEN;
        modes[1] = MODE_OPEN;
        modes[2] = MODE_OPEN;
        if (r.sector != 3'd0) begin
            modes[(int'(r.sector) - 1) / 2]     = MODE_POS;
            modes[(int'(r.sector) / 2 + 1) % 3] = MODE_NEG;
        end
        r.u = modes[0];
        r.v = modes[1];
        r.w = modes[2];
        // zero counts with the negative side, full negative scale saturates
        if (duty_req > 0) begin
            hot = MODE_POS;
            mag = int'(duty_req);
        end else begin
            hot = MODE_NEG;
            mag = -int'(duty_req);
        end
        if (mag > int'(DUTY_MAX)) begin
            mag = int'(DUTY_MAX);
        end
        duty_word = 15'(mag);
        r.duty_u = (modes[0] == hot) ? duty_word : 15'd0;
        r.duty_v = (modes[1] == hot) ? duty_word : 15'd0;
        r.duty_w = (modes[2] == hot) ? duty_word : 15'd0;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at result %0d: %s", results_seen, what);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    // offers one hall sample, called and returning at a falling edge
    task automatic send_hall(input logic [2:0] hall, input logic signed [15:0] duty_req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, duty_req, hall};
        do @(posedge aclk); while (!s_axis_tready);
        pending_drives.push_back(predict_drive(hall, duty_req));
        transfers_in++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        while (pending_drives.size() != 0) begin
            @(negedge aclk);
        end
        // spare cycles after the last expected result catch any stray transfer
        repeat (4) @(negedge aclk);
    endtask

    // reset state, every hall code, sector moves in both senses including some through sector 0,
    // and the duty extremes
    task automatic test_sector_walk_directed();
        // forward lap, a backward step with angle wrap, hold, then moves via the invalid codes
        localparam logic [50:0] WALK_CODES = {3'd2, 3'd7, 3'd0, 3'd3, 3'd7, 3'd1, 3'd0,
                                              3'd6, 3'd6, 3'd4, 3'd5, 3'd4, 3'd6, 3'd2,
                                              3'd3, 3'd1, 3'd5};
        logic signed [15:0] duty_req;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 17; i++) begin
            case (i % 7)
                0:       duty_req = 16'sd32767;
                1:       duty_req = -16'sd32767;
                2:       duty_req = 16'sh8000;
                3:       duty_req = 16'sd0;
                4:       duty_req = 16'sd1;
                5:       duty_req = -16'sd1;
                default: duty_req = 16'($urandom);
            endcase
            send_hall(WALK_CODES[i * 3 +: 3], duty_req);
        end
        s_axis_tvalid <= 1'b0;
        drain_results();
    endtask

    // mostly clean rotation with random duty, with reversals, dwell, jumps and bad codes
    task automatic test_rotation_random(input int items, input int idle_pct,
                                        input int stall_pct);
        int                 step;
        int                 pick;
        logic [2:0]         walk;
        logic [2:0]         code;
        logic signed [15:0] duty_req;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        step = ($urandom_range(1) == 0) ? 1 : -1;
        walk = 3'($urandom_range(6, 1));
        code = CODE_BY_SECTOR[int'(walk) * 3 +: 3];
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                step = -step;
            end else if (pick < 72) begin
                if (step > 0) begin
                    walk = (walk == 3'd6) ? 3'd1 : walk + 3'd1;
                end else begin
                    walk = (walk == 3'd1) ? 3'd6 : walk - 3'd1;
                end
                code = CODE_BY_SECTOR[int'(walk) * 3 +: 3];
            end else if (pick < 92 && pick >= 82) begin
                code = 3'($urandom_range(7));
                if (SECTOR_BY_CODE[int'(code) * 3 +: 3] != 3'd0) begin
                    walk = SECTOR_BY_CODE[int'(code) * 3 +: 3];
                end
            end else if (pick >= 92) begin
                code = ($urandom_range(1) == 0) ? 3'd0 : 3'd7;
            end
            // dwell on the same code for the 72..81 band
            case ($urandom_range(9))
                0:       duty_req = ($urandom_range(1) == 0) ? 16'sh8000 : 16'sh7fff;
                1:       duty_req = ($urandom_range(1) == 0) ? 16'sd0 : -16'sd32767;
                2, 3:    duty_req = $signed(16'($urandom_range(255))) - 16'sd128;
                default: duty_req = 16'($urandom);
            endcase
            send_hall(code, duty_req);
        end
        s_axis_tvalid <= 1'b0;
        drain_results();
    endtask

    // receiver holds off long enough for the queue to fill and the input to stall
    task automatic test_output_hold_off();
        hold_left = 300;
        test_rotation_random(150, 0, 0);
    endtask

    // result side ready, random stalls unless a hold-off is running
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compares every result transfer against the oldest expectation
    always @(posedge aclk) begin
        drive_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_drives.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = pending_drives.pop_front();
                compare_field("sector", int'(m_axis_tdata[2:0]), int'(want.sector));
                compare_field("direction", int'($signed(m_axis_tdata[6:3])),
                              int'(want.direction));
                compare_field("hall_angle", int'($signed(m_axis_tdata[10:7])),
                              int'(want.angle));
                compare_field("phase_u_mode", int'(m_axis_tdata[12:11]), int'(want.u));
                compare_field("phase_v_mode", int'(m_axis_tdata[14:13]), int'(want.v));
                compare_field("phase_w_mode", int'(m_axis_tdata[16:15]), int'(want.w));
                compare_field("duty_u", int'(m_axis_tdata[31:17]), int'(want.duty_u));
                compare_field("duty_v", int'(m_axis_tdata[46:32]), int'(want.duty_v));
                compare_field("duty_w", int'(m_axis_tdata[61:47]), int'(want.duty_w));
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_drives.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        last_sector    = 3'd0;
        held_direction = 4'sd0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_sector_walk_directed();
        test_rotation_random(350, 0, 0);
        test_rotation_random(350, 48, 0);
        test_rotation_random(350, 0, 48);
        test_rotation_random(350, 7, 7);
        test_output_hold_off();

        if (pending_drives.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_drives.size()));
        end
        $display("%0d hall samples in, %0d drive results checked", transfers_in, results_seen);
        $display("all hall codes, both rotation senses, duty extremes, idle and hold-off phases");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hssc_pkg.sv
rtl/hssc_front.sv
rtl/hssc_queue.sv
rtl/hssc_back.sv
rtl/hall_six_step_commutator.sv
verif/tb_hall_six_step_commutator.sv
